// ===== design/assert_macros.svh =====
// assertion helpers for the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication, checked outside reset
`define ASSERT_IMPL(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, checked outside reset
`define ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_IMPL(name, clk, rst_n, ante, cons)
`define ASSERT_NEXT(name, clk, rst_n, ante, cons)

`endif

`endif

// ===== design/tsil_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tsil_pkg;

    localparam logic [4:0] MAX_INSN_BYTES = 5'd15;

    localparam logic [7:0] OPC_OPSIZE   = 8'h66;
    localparam logic [7:0] OPC_ADDRSIZE = 8'h67;
    localparam logic [7:0] OPC_INT3     = 8'hCC;
    localparam logic [7:0] OPC_INTN     = 8'hCD;
    localparam logic [7:0] OPC_INTO     = 8'hCE;
    localparam logic [7:0] OPC_IRET     = 8'hCF;
    localparam logic [7:0] OPC_JMPF     = 8'hEA;
    localparam logic [7:0] OPC_CALLF    = 8'h9A;
    localparam logic [7:0] OPC_GRP5     = 8'hFF;
    localparam logic [7:0] OPC_SEG_ES   = 8'h26;
    localparam logic [7:0] OPC_SEG_CS   = 8'h2E;
    localparam logic [7:0] OPC_SEG_SS   = 8'h36;
    localparam logic [7:0] OPC_SEG_DS   = 8'h3E;
    localparam logic [7:0] OPC_SEG_FS   = 8'h64;
    localparam logic [7:0] OPC_SEG_GS   = 8'h65;
    localparam logic [7:0] OPC_REPNE    = 8'hF2;
    localparam logic [7:0] OPC_REP      = 8'hF3;

    localparam logic [1:0] MOD_NODISP = 2'd0;
    localparam logic [1:0] MOD_DISP32 = 2'd2;
    localparam logic [1:0] MOD_REG    = 2'd3;
    localparam logic [2:0] RM_SIB     = 3'd4;
    localparam logic [2:0] RM_DISP32  = 3'd5;
    localparam logic [2:0] RM_DISP16  = 3'd6;
    localparam logic [2:0] BASE_NONE  = 3'd5;

    localparam logic CFG_DEFAULT_32BIT = 1'b0;
    localparam logic CFG_LONG_MODE     = 1'b1;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_OPC   = 2'd1,
        PH_MODRM = 2'd2,
        PH_SIB   = 2'd3
    } phase_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_UNSUP     = 3'd1,
        ST_REG_OPND  = 3'd2,
        ST_LONG_MODE = 3'd3,
        ST_TOO_LONG  = 3'd4
    } status_t;

    typedef struct packed {
        logic [7:0] code_byte;
        logic       first_byte;
    } tsil_in_t;

    typedef struct packed {
        logic [3:0] insn_length;
        logic [2:0] status;
    } tsil_out_t;

    typedef struct packed {
        phase_t     phase;
        logic       opsize_seen;
        logic       addrsize_seen;
        logic [3:0] bytes_taken;
    } tsil_state_t;

    function automatic tsil_out_t finish_word(input logic [4:0] total);
        tsil_out_t w;
        if (total > MAX_INSN_BYTES)
        begin
            w.insn_length = 4'd0;
            w.status      = ST_TOO_LONG;
        end
        else
        begin
            w.insn_length = total[3:0];
            w.status      = ST_OK;
        end
        return w;
    endfunction

    function automatic tsil_out_t error_word(input status_t st);
        tsil_out_t w;
        w.insn_length = 4'd0;
        w.status      = st;
        return w;
    endfunction

endpackage

`default_nettype wire

// ===== design/tsil_decode.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tsil_decode (
    input  wire tsil_pkg::tsil_state_t cur,
    input  wire tsil_pkg::tsil_in_t    word,
    input  wire                        default_32bit,
    input  wire                        long_mode_active,
    output tsil_pkg::tsil_state_t      nxt,
    output logic                       emit,
    output tsil_pkg::tsil_out_t        result
);

    tsil_pkg::phase_t ph_eff;
    logic [3:0]       bytes_eff;
    logic [4:0]       n;
    logic             op_eff;
    logic             ad_eff;
    logic             long_hit;
    logic             is_prefix;
    logic [7:0]       c;
    logic [1:0]       modrm_mod;
    logic [2:0]       modrm_rm;
    logic             addr16;
    logic [4:0]       mod_ext;

    assign c         = word.code_byte;
    assign long_hit  = word.first_byte && long_mode_active;
    assign ph_eff    = word.first_byte ? (long_mode_active ? tsil_pkg::PH_IDLE : tsil_pkg::PH_OPC)
                                       : cur.phase;
    assign bytes_eff = word.first_byte ? 4'd0 : cur.bytes_taken;
    assign op_eff    = word.first_byte ? 1'b0 : cur.opsize_seen;
    assign ad_eff    = word.first_byte ? 1'b0 : cur.addrsize_seen;
    assign n         = {1'b0, bytes_eff} + 5'd1;
    assign modrm_mod = c[7:6];
    assign modrm_rm  = c[2:0];
    assign mod_ext   = {3'd0, modrm_mod};
    assign addr16    = (default_32bit == ad_eff);

    assign is_prefix = (c == tsil_pkg::OPC_OPSIZE) || (c == tsil_pkg::OPC_ADDRSIZE) ||
                       (c == tsil_pkg::OPC_SEG_ES) || (c == tsil_pkg::OPC_SEG_CS) ||
                       (c == tsil_pkg::OPC_SEG_SS) || (c == tsil_pkg::OPC_SEG_DS) ||
                       (c == tsil_pkg::OPC_SEG_FS) || (c == tsil_pkg::OPC_SEG_GS) ||
                       (c == tsil_pkg::OPC_REPNE)  || (c == tsil_pkg::OPC_REP);

    // result side
    always_comb
    begin
        emit   = 1'b0;
        result = tsil_pkg::error_word(tsil_pkg::ST_OK);
        if (long_hit)
        begin
            emit   = 1'b1;
            result = tsil_pkg::error_word(tsil_pkg::ST_LONG_MODE);
        end
        else
        begin
            case (ph_eff)
                tsil_pkg::PH_OPC:
                begin
                    if (is_prefix || c == tsil_pkg::OPC_GRP5)
                    begin
                        // no room left for the opcode or modrm still to come
                        if (n >= tsil_pkg::MAX_INSN_BYTES)
                        begin
                            emit   = 1'b1;
                            result = tsil_pkg::error_word(tsil_pkg::ST_TOO_LONG);
                        end
                    end
                    else if (c == tsil_pkg::OPC_INT3 || c == tsil_pkg::OPC_INTO ||
                             c == tsil_pkg::OPC_IRET)
                    begin
                        emit   = 1'b1;
                        result = tsil_pkg::finish_word(n);
                    end
                    else if (c == tsil_pkg::OPC_INTN)
                    begin
                        emit   = 1'b1;
                        result = tsil_pkg::finish_word(n + 5'd1);
                    end
                    else if (c == tsil_pkg::OPC_JMPF || c == tsil_pkg::OPC_CALLF)
                    begin
                        emit   = 1'b1;
                        result = tsil_pkg::finish_word(n + ((default_32bit ^ op_eff)
                                                            ? 5'd6 : 5'd4));
                    end
                    else
                    begin
                        emit   = 1'b1;
                        result = tsil_pkg::error_word(tsil_pkg::ST_UNSUP);
                    end
                end
                tsil_pkg::PH_MODRM:
                begin
                    emit = 1'b1;
                    if (modrm_mod == tsil_pkg::MOD_REG)
                        result = tsil_pkg::error_word(tsil_pkg::ST_REG_OPND);
                    else if (addr16)
                        result = tsil_pkg::finish_word(n +
                            ((modrm_mod == tsil_pkg::MOD_NODISP &&
                              modrm_rm == tsil_pkg::RM_DISP16) ? 5'd2 : mod_ext));
                    else if (modrm_rm == tsil_pkg::RM_SIB)
                    begin
                        if (modrm_mod == tsil_pkg::MOD_NODISP)
                        begin
                            // sib byte follows, unless it cannot fit
                            emit = (n >= tsil_pkg::MAX_INSN_BYTES);
                            result = tsil_pkg::error_word(tsil_pkg::ST_TOO_LONG);
                        end
                        else
                            result = tsil_pkg::finish_word(n + 5'd1 +
                                ((modrm_mod == tsil_pkg::MOD_DISP32) ? 5'd4 : mod_ext));
                    end
                    else
                        result = tsil_pkg::finish_word(n +
                            ((modrm_mod == tsil_pkg::MOD_DISP32 ||
                              (modrm_mod == tsil_pkg::MOD_NODISP &&
                               modrm_rm == tsil_pkg::RM_DISP32)) ? 5'd4 : mod_ext));
                end
                tsil_pkg::PH_SIB:
                begin
                    emit   = 1'b1;
                    result = tsil_pkg::finish_word(n +
                        ((c[2:0] == tsil_pkg::BASE_NONE) ? 5'd4 : 5'd0));
                end
                default:
                begin
                    emit = 1'b0;
                end
            endcase
        end
    end

    // state side
    always_comb
    begin
        nxt.opsize_seen   = op_eff;
        nxt.addrsize_seen = ad_eff;
        nxt.bytes_taken   = bytes_eff;
        nxt.phase         = ph_eff;
        if (ph_eff != tsil_pkg::PH_IDLE)
            nxt.bytes_taken = n[3:0];
        if (ph_eff == tsil_pkg::PH_OPC && c == tsil_pkg::OPC_OPSIZE)
            nxt.opsize_seen = 1'b1;
        if (ph_eff == tsil_pkg::PH_OPC && c == tsil_pkg::OPC_ADDRSIZE)
            nxt.addrsize_seen = 1'b1;
        if (emit)
            nxt.phase = tsil_pkg::PH_IDLE;
        else if (ph_eff == tsil_pkg::PH_OPC && c == tsil_pkg::OPC_GRP5)
            nxt.phase = tsil_pkg::PH_MODRM;
        else if (ph_eff == tsil_pkg::PH_MODRM)
            nxt.phase = tsil_pkg::PH_SIB;
    end

endmodule

`default_nettype wire

// ===== design/task_switch_insn_length.sv =====
// instruction length decoder for x86 task-switching instructions
// in channel: one code byte per word, first_byte set on the opening byte of
//   each instruction; a first byte always restarts decoding
// out channel: insn_length and status, one word per decoded instruction, sent
//   as soon as the length or an error is known; bytes after that are dropped
//   until the next first byte
// cfg channel: cfg_index 0 writes default_32bit, 1 writes long_mode_active;
//   always ready, write only while no instruction is in flight
// throughput: one byte per cycle unless the receiver stalls; the decode is a single pass of logic
//   between the input register and the result register
// an accepted byte is held in the input register, and its result then in the result register behind out_valid
// a stalled receiver holds the result register; the input register then
//   fills and in_ready drops until the result is taken
// reset clears both registers' valid bits, the decode state and config
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module task_switch_insn_length (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 in_valid,
    output logic                in_ready,
    input  wire tsil_pkg::tsil_in_t in_data,
    output logic                out_valid,
    input  wire                 out_ready,
    output tsil_pkg::tsil_out_t out_data,
    input  wire                 cfg_valid,
    output logic                cfg_ready,
    input  wire                 cfg_index,
    input  wire                 cfg_data
);

    logic                  s1_valid_reg;
    logic                  s1_valid_next;
    tsil_pkg::tsil_in_t    s1_data_reg;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    tsil_pkg::tsil_out_t   out_data_reg;
    tsil_pkg::tsil_state_t state_reg;
    tsil_pkg::tsil_state_t state_next;
    logic                  default_32bit_reg;
    logic                  long_mode_reg;
    logic                  advance;
    logic                  dec_emit;
    tsil_pkg::tsil_out_t   dec_result;

    tsil_decode u_decode (
        .cur              (state_reg),
        .word             (s1_data_reg),
        .default_32bit    (default_32bit_reg),
        .long_mode_active (long_mode_reg),
        .nxt              (state_next),
        .emit             (dec_emit),
        .result           (dec_result)
    );

    assign advance   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !s1_valid_reg || advance;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_valid && in_ready)
            s1_valid_next = 1'b1;
        else if (advance)
            s1_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (advance && dec_emit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
            state_reg         <= '{phase: tsil_pkg::PH_IDLE, opsize_seen: 1'b0,
                                   addrsize_seen: 1'b0, bytes_taken: 4'd0};
            default_32bit_reg <= 1'b0;
            long_mode_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
                state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == tsil_pkg::CFG_DEFAULT_32BIT)
                    default_32bit_reg <= cfg_data;
                if (cfg_index == tsil_pkg::CFG_LONG_MODE)
                    long_mode_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            s1_data_reg <= in_data;
        if (advance && dec_emit)
            out_data_reg <= dec_result;
    end

    `ASSERT_IMPL(a_err_len_zero, clk, rst_n,
        out_valid_reg && out_data_reg.status != tsil_pkg::ST_OK,
        out_data_reg.insn_length == 4'd0)
    `ASSERT_IMPL(a_ok_len_nonzero, clk, rst_n,
        out_valid_reg && out_data_reg.status == tsil_pkg::ST_OK,
        out_data_reg.insn_length != 4'd0)
    `ASSERT_NEXT(a_idle_after_result, clk, rst_n,
        advance && dec_emit, state_reg.phase == tsil_pkg::PH_IDLE)
    `ASSERT_IMPL(a_no_overwrite, clk, rst_n,
        out_valid_reg && !out_ready, !advance)

endmodule

`default_nettype wire
